FILE: rtl/rpa_pkg.sv
package rpa_pkg;

   // item modes
   localparam logic [2:0] MODE_START  = 3'd0;
   localparam logic [2:0] MODE_ALLOC  = 3'd1;
   localparam logic [2:0] MODE_FREE   = 3'd2;
   localparam logic [2:0] MODE_READ   = 3'd3;
   localparam logic [2:0] MODE_ADDREF = 3'd4;

   // result status codes
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_NO_PAGES     = 3'd1;
   localparam logic [2:0] ST_BAD_ADDR     = 3'd2;
   localparam logic [2:0] ST_ALREADY_FREE = 3'd3;
   localparam logic [2:0] ST_NOT_STARTED  = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_REGION_BASE  = 2'd0;
   localparam logic [1:0] CSR_FIRST_USABLE = 2'd1;
   localparam logic [1:0] CSR_REGION_LIMIT = 2'd2;

   localparam logic [31:0] RESET_REGION_BASE  = 32'h8000_0000;
   localparam logic [31:0] RESET_FIRST_USABLE = 32'h8000_0000;
   localparam logic [31:0] RESET_REGION_LIMIT = 32'h8800_0000;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] page_address;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] granted_address;
      logic [7:0]  ref_value;
      logic        returned;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic eval;
      logic clear;
      logic exec;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_start;
      logic clear_last;
   } sts_type;

endpackage

FILE: rtl/refcounted_page_allocator.sv
// Reference-counted page allocator.
// Request channel (req_): one word holds a mode and a page address; it is
// taken when req_valid is high and req_stall is low. Modes: start, allocate,
// free, read count, add reference.
// Response channel (rsp_): exactly one word per request, in request order,
// held in an output register until the receiver drops rsp_stall.
// Configuration (csr_): write region_base, first_usable and region_limit
// by index while the block is idle; they take effect on the next request.
// Allocate, free, read count and add reference pass from acceptance through
// a memory read state and an update state to rsp_valid; a new request is
// taken only once the block is back in idle, never while one is in flight.
// Start sweeps the count memory one entry per cycle.
// The request rate is set by the single-port count memory and the return stack
// memory, each read through a registered output before its write.
// After reset the block is not started; allocate, free, read count and add
// reference answer "not started". While a response is stalled, the block
// still takes one new request and holds it until the output register frees up.
module refcounted_page_allocator #(
   parameter int PAGE_BITS  = 12,
   parameter int NUM_PAGES  = 32768,
   parameter int COUNT_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wr_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  rpa_pkg::req_type  req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rpa_pkg::rsp_type  rsp_data
);
   import rpa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rpa_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rpa_dp #(
      .PAGE_BITS  (PAGE_BITS),
      .NUM_PAGES  (NUM_PAGES),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .sts         (sts)
   );

`ifndef SYNTH
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.eval, cmd.clear, cmd.exec}))
      else $error("more than one datapath command at once");

   a_accept_capture: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> cmd.capture)
      else $error("request word taken without capture");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> !(rsp_valid && rsp_stall))
      else $error("result written over a stalled response word");

   a_exec_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid)
      else $error("finished request left no response word");
`endif

endmodule

FILE: rtl/rpa_ctl.sv
module rpa_ctl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  rpa_pkg::sts_type sts,
   output rpa_pkg::cmd_type cmd
);
   import rpa_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EVAL  = 2'd1;
   localparam logic [1:0] S_CLEAR = 2'd2;
   localparam logic [1:0] S_EXEC  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.is_start ? S_CLEAR : S_EXEC;
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // wait until the output word slot is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.exec | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/rpa_dp.sv
module rpa_dp #(
   parameter int PAGE_BITS  = 12,
   parameter int NUM_PAGES  = 32768,
   parameter int COUNT_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wr_data,
   input  rpa_pkg::req_type  req_data,
   output rpa_pkg::rsp_type  rsp_data,
   input  rpa_pkg::cmd_type  cmd,
   output rpa_pkg::sts_type  sts
);
   import rpa_pkg::*;

   localparam int IDXW  = $clog2(NUM_PAGES);
   localparam int FILLW = IDXW + 1;
   localparam logic [32:0] PAGE_SIZE = 33'd1 << PAGE_BITS;
   localparam logic [31:0] OFS_MASK  = 32'(PAGE_SIZE - 33'd1);
   localparam logic [32:0] OFS_MASK33 = {1'b0, OFS_MASK};
   localparam logic [31:0] NUM32     = 32'(NUM_PAGES);
   localparam logic [FILLW-1:0] FILL_FULL = FILLW'(NUM_PAGES);
   localparam logic [IDXW-1:0]  IDX_LAST  = IDXW'(NUM_PAGES - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   // configuration
   logic [31:0] base_ff, base_in;
   logic [31:0] fu_ff, fu_in;
   logic [31:0] limit_ff, limit_in;

   // item and allocator state
   req_type          req_ff, req_in;
   rsp_type          rsp_ff, rsp_in;
   logic [FILLW-1:0] fill_ff, fill_in;
   logic [FILLW-1:0] fresh_top_ff, fresh_top_in;
   logic [FILLW-1:0] fresh_base_ff, fresh_base_in;
   logic             started_ff, started_in;
   logic [IDXW-1:0]  clr_ff, clr_in;
   logic [32:0]      lo_ff, lo_in;
   logic [FILLW-1:0] hi_ff, hi_in;
   logic             addr_ok_ff, addr_ok_in;
   logic [IDXW-1:0]  idx_ff, idx_in;

   // memories
   logic [COUNT_BITS-1:0] cnt_mem [NUM_PAGES];
   logic [IDXW-1:0]       stk_mem [NUM_PAGES];
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic [IDXW-1:0]       stk_rd_ff;
   logic                  cnt_we;
   logic [IDXW-1:0]       cnt_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic                  stk_we;
   logic                  stk_re;
   logic [IDXW-1:0]       stk_raddr;

   logic [31:0]      base_al;
   logic [31:0]      pa;
   logic [32:0]      pa_end;
   logic [31:0]      pa_pidx;
   logic             addr_ok;
   logic [32:0]      lo_round;
   logic [32:0]      lo_eff;
   logic [31:0]      lim_pidx;
   logic [FILLW-1:0] hi_idx;
   logic [32:0]      lo_pidx;
   logic [FILLW-1:0] lo_idx;
   logic [FILLW-1:0] fill_m1;
   logic [FILLW-1:0] fresh_m1;
   logic [IDXW-1:0]  alloc_idx;
   logic [COUNT_BITS-1:0] new_cnt;
   logic [COUNT_BITS+7:0] cnt_wide;

   assign base_al = base_ff & ~OFS_MASK;
   assign pa      = req_ff.page_address;

   // address check for free, read count and add reference
   assign pa_end  = {1'b0, pa} + PAGE_SIZE;
   assign pa_pidx = (pa - base_al) >> PAGE_BITS;
   assign addr_ok = ((pa & OFS_MASK) == 32'd0) && (pa >= fu_ff) && (pa >= base_al)
                    && (pa_end <= {1'b0, limit_ff}) && (pa_pidx < NUM32);

   // never-used run bounds for start
   assign lo_round = ({1'b0, fu_ff} + PAGE_SIZE - 33'd1) & ~OFS_MASK33;
   assign lo_eff   = (lo_round < {1'b0, base_al}) ? {1'b0, base_al} : lo_round;
   assign lim_pidx = (limit_ff - base_al) >> PAGE_BITS;
   assign hi_idx   = (limit_ff < base_al) ? '0 :
                     (lim_pidx > NUM32) ? FILL_FULL : lim_pidx[FILLW-1:0];
   assign lo_pidx  = (lo_ff - {1'b0, base_al}) >> PAGE_BITS;
   assign lo_idx   = (lo_pidx > 33'(hi_ff)) ? hi_ff : lo_pidx[FILLW-1:0];

   assign fill_m1   = fill_ff - FILLW'(1);
   assign fresh_m1  = fresh_top_ff - FILLW'(1);
   assign stk_raddr = fill_m1[IDXW-1:0];
   assign stk_re    = cmd.eval && (fill_ff != '0);

   assign sts.is_start   = (req_ff.mode == MODE_START);
   assign sts.clear_last = (clr_ff == IDX_LAST);

   always_comb begin
      base_in       = base_ff;
      fu_in         = fu_ff;
      limit_in      = limit_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      fill_in       = fill_ff;
      fresh_top_in  = fresh_top_ff;
      fresh_base_in = fresh_base_ff;
      started_in    = started_ff;
      clr_in        = clr_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      addr_ok_in    = addr_ok_ff;
      idx_in        = idx_ff;
      cnt_we        = 1'b0;
      cnt_waddr     = idx_ff;
      cnt_wdata     = '0;
      stk_we        = 1'b0;
      alloc_idx     = '0;
      new_cnt       = '0;
      cnt_wide      = '0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_REGION_BASE:  base_in  = csr_wr_data;
            CSR_FIRST_USABLE: fu_in    = csr_wr_data;
            CSR_REGION_LIMIT: limit_in = csr_wr_data;
            default: ;
         endcase
      end

      if (cmd.capture) begin
         req_in = req_data;
      end

      if (cmd.eval) begin
         addr_ok_in = addr_ok;
         idx_in     = pa_pidx[IDXW-1:0];
         lo_in      = lo_eff;
         hi_in      = hi_idx;
      end

      // sweep the count table, then open the never-used run
      if (cmd.clear) begin
         cnt_we    = 1'b1;
         cnt_waddr = clr_ff;
         cnt_wdata = '0;
         if (sts.clear_last) begin
            clr_in        = '0;
            fill_in       = '0;
            fresh_base_in = lo_idx;
            fresh_top_in  = hi_ff;
            started_in    = 1'b1;
         end else begin
            clr_in = clr_ff + IDXW'(1);
         end
      end

      if (cmd.exec) begin
         rsp_in = '0;
         rsp_in.status = ST_OK;
         if (req_ff.mode != MODE_START && req_ff.mode <= MODE_ADDREF && !started_ff) begin
            rsp_in.status = ST_NOT_STARTED;
         end else begin
            case (req_ff.mode) inside
               MODE_ALLOC: begin
                  if (fill_ff != '0) begin
                     fill_in   = fill_m1;
                     alloc_idx = stk_rd_ff;
                  end else if (fresh_top_ff > fresh_base_ff) begin
                     fresh_top_in = fresh_m1;
                     alloc_idx    = fresh_m1[IDXW-1:0];
                  end else begin
                     rsp_in.status = ST_NO_PAGES;
                  end
                  if (rsp_in.status == ST_OK) begin
                     cnt_we    = 1'b1;
                     cnt_waddr = alloc_idx;
                     cnt_wdata = COUNT_ONE;
                     rsp_in.granted_address = base_al + (32'(alloc_idx) << PAGE_BITS);
                     rsp_in.ref_value       = 8'd1;
                  end
               end
               MODE_FREE, MODE_READ, MODE_ADDREF: begin
                  if (!addr_ok_ff) begin
                     rsp_in.status = ST_BAD_ADDR;
                  end else if (req_ff.mode == MODE_READ) begin
                     cnt_wide         = {8'd0, cnt_rd_ff};
                     rsp_in.ref_value = cnt_wide[7:0];
                  end else if (cnt_rd_ff == '0) begin
                     rsp_in.status = ST_ALREADY_FREE;
                  end else begin
                     if (req_ff.mode == MODE_ADDREF) begin
                        // saturate at the top count
                        new_cnt = (cnt_rd_ff == COUNT_MAX) ? cnt_rd_ff
                                                            : cnt_rd_ff + COUNT_ONE;
                     end else begin
                        new_cnt = cnt_rd_ff - COUNT_ONE;
                        if (new_cnt == '0 && fill_ff < FILL_FULL) begin
                           stk_we          = 1'b1;
                           fill_in         = fill_ff + FILLW'(1);
                           rsp_in.returned = 1'b1;
                        end
                     end
                     cnt_we           = 1'b1;
                     cnt_waddr        = idx_ff;
                     cnt_wdata        = new_cnt;
                     cnt_wide         = {8'd0, new_cnt};
                     rsp_in.ref_value = cnt_wide[7:0];
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= RESET_REGION_BASE;
         fu_ff         <= RESET_FIRST_USABLE;
         limit_ff      <= RESET_REGION_LIMIT;
         fill_ff       <= '0;
         fresh_top_ff  <= '0;
         fresh_base_ff <= '0;
         started_ff    <= 1'b0;
         clr_ff        <= '0;
      end else begin
         base_ff       <= base_in;
         fu_ff         <= fu_in;
         limit_ff      <= limit_in;
         fill_ff       <= fill_in;
         fresh_top_ff  <= fresh_top_in;
         fresh_base_ff <= fresh_base_in;
         started_ff    <= started_in;
         clr_ff        <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      addr_ok_ff <= addr_ok_in;
      idx_ff     <= idx_in;
   end

   // count table: one write port, registered read
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cmd.eval) begin
         cnt_rd_ff <= cnt_mem[pa_pidx[IDXW-1:0]];
      end
   end

   // return stack: push at the fill level, pop reads one below it
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[fill_ff[IDXW-1:0]] <= idx_ff;
      end
      if (stk_re) begin
         stk_rd_ff <= stk_mem[stk_raddr];
      end
   end

   assign rsp_data = rsp_ff;

endmodule
